FILE: rtl/core/tia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed ID allocator package
// Shared sizes, codes, memory request structs and address helpers.
// ----------------------------------------------------------------------------
package tia_pkg;

  // Sizing
  localparam int ID_WIDTH     = 32;
  localparam int ACTIVE_DEPTH = 64;
  localparam int FREED_DEPTH  = 64;
  localparam int NUM_CLASSES  = 3;
  localparam int CLS_W        = 2;   // width of the class field

  localparam int ACT_IW    = $clog2(ACTIVE_DEPTH);
  localparam int FRD_IW    = $clog2(FREED_DEPTH);
  localparam int ACT_CW    = $clog2(ACTIVE_DEPTH + 1);
  localparam int FRD_CW    = $clog2(FREED_DEPTH + 1);
  localparam int ACT_WORDS = NUM_CLASSES * ACTIVE_DEPTH;
  localparam int FRD_WORDS = NUM_CLASSES * FREED_DEPTH;
  localparam int ACT_AW    = $clog2(ACT_WORDS);
  localparam int FRD_AW    = $clog2(FRD_WORDS);

  // Codes
  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RECLAIM = 2'd1,
    ACT_CLEAR   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_ACTIVE = 2'd1,
    STAT_FULL       = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP,
    ST_SCAN,
    ST_SWAP,
    ST_RESP
  } state_e;

  // Memory port requests
  typedef struct packed {
    logic                we;
    logic [ACT_AW-1:0]   waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [ACT_AW-1:0]   raddr;
  } act_req_t;

  typedef struct packed {
    logic                we;
    logic [FRD_AW-1:0]   waddr;
    logic [ID_WIDTH-1:0] wdata;
    logic [FRD_AW-1:0]   raddr;
  } frd_req_t;

  // Finished result word
  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    status_e             status;
  } result_t;

  // Flat addresses: each class owns a contiguous region
  function automatic logic [ACT_AW-1:0] act_addr(input logic [CLS_W-1:0]  cls,
                                                 input logic [ACT_IW-1:0] idx);
    act_addr = ACT_AW'(cls) * ACT_AW'(ACTIVE_DEPTH) + ACT_AW'(idx);
  endfunction

  function automatic logic [FRD_AW-1:0] frd_addr(input logic [CLS_W-1:0]  cls,
                                                 input logic [FRD_IW-1:0] idx);
    frd_addr = FRD_AW'(cls) * FRD_AW'(FREED_DEPTH) + FRD_AW'(idx);
  endfunction

endpackage

FILE: rtl/core/tia_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module tia_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tia_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed ID allocator control
// Per-class counters and list counts, and the sequencer that reads, scans
// and writes back the active and freed memories.
// ----------------------------------------------------------------------------
module tia_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input word
  input  logic                         in_fire_i,
  input  logic [1:0]                   action_i,
  input  logic [tia_pkg::CLS_W-1:0]    id_class_i,
  input  logic [tia_pkg::ID_WIDTH-1:0] release_id_i,
  output logic                         busy_o,
  // memories
  output tia_pkg::act_req_t            act_req_o,
  input  logic [tia_pkg::ID_WIDTH-1:0] act_rdata_i,
  output tia_pkg::frd_req_t            frd_req_o,
  input  logic [tia_pkg::ID_WIDTH-1:0] frd_rdata_i,
  // result
  output logic                         res_valid_o,
  output tia_pkg::result_t             res_o,
  input  logic                         res_ready_i
);

  tia_pkg::state_e state_q, state_d;

  // Latched input word
  logic [1:0]                   action_q;
  logic [tia_pkg::CLS_W-1:0]    class_q;
  logic [tia_pkg::ID_WIDTH-1:0] rel_q;

  // Per-class state
  logic [tia_pkg::ID_WIDTH-1:0] cnt_q     [tia_pkg::NUM_CLASSES];
  logic [tia_pkg::ID_WIDTH-1:0] cnt_d     [tia_pkg::NUM_CLASSES];
  logic [tia_pkg::ACT_CW-1:0]   act_cnt_q [tia_pkg::NUM_CLASSES];
  logic [tia_pkg::ACT_CW-1:0]   act_cnt_d [tia_pkg::NUM_CLASSES];
  logic [tia_pkg::FRD_CW-1:0]   frd_cnt_q [tia_pkg::NUM_CLASSES];
  logic [tia_pkg::FRD_CW-1:0]   frd_cnt_d [tia_pkg::NUM_CLASSES];

  // Scan index / match slot
  logic [tia_pkg::ACT_IW-1:0]   idx_q, idx_d;

  logic [tia_pkg::ID_WIDTH-1:0] res_id_q, res_id_d;
  tia_pkg::status_e             res_status_q, res_status_d;

  // Current-class views
  logic                         cls_ok;
  logic [tia_pkg::ID_WIDTH-1:0] cnt_inc;
  logic [tia_pkg::ACT_CW-1:0]   cur_act_cnt, act_cnt_m1;
  logic [tia_pkg::FRD_CW-1:0]   cur_frd_cnt, frd_cnt_m1;
  logic                         act_full, frd_full;
  logic [tia_pkg::ACT_IW-1:0]   act_push_idx, last_idx;
  logic [tia_pkg::FRD_IW-1:0]   frd_push_idx, frd_pop_idx;

  assign cls_ok       = class_q < tia_pkg::CLS_W'(tia_pkg::NUM_CLASSES);
  assign cnt_inc      = cnt_q[class_q] + 1'b1;
  assign cur_act_cnt  = act_cnt_q[class_q];
  assign cur_frd_cnt  = frd_cnt_q[class_q];
  assign act_cnt_m1   = cur_act_cnt - 1'b1;
  assign frd_cnt_m1   = cur_frd_cnt - 1'b1;
  assign act_full     = cur_act_cnt >= tia_pkg::ACT_CW'(tia_pkg::ACTIVE_DEPTH);
  assign frd_full     = cur_frd_cnt >= tia_pkg::FRD_CW'(tia_pkg::FREED_DEPTH);
  assign act_push_idx = cur_act_cnt[tia_pkg::ACT_IW-1:0];
  assign last_idx     = act_cnt_m1[tia_pkg::ACT_IW-1:0];
  assign frd_push_idx = cur_frd_cnt[tia_pkg::FRD_IW-1:0];
  assign frd_pop_idx  = frd_cnt_m1[tia_pkg::FRD_IW-1:0];

  // State register and per-class control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tia_pkg::ST_IDLE;
      for (int i = 0; i < tia_pkg::NUM_CLASSES; i++) begin
        cnt_q[i]     <= '0;
        act_cnt_q[i] <= '0;
        frd_cnt_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      act_cnt_q <= act_cnt_d;
      frd_cnt_q <= frd_cnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      action_q <= action_i;
      class_q  <= id_class_i;
      rel_q    <= release_id_i;
    end
    idx_q        <= idx_d;
    res_id_q     <= res_id_d;
    res_status_q <= res_status_d;
  end

  // Sequencer: next state, memory requests, list updates
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    act_cnt_d    = act_cnt_q;
    frd_cnt_d    = frd_cnt_q;
    idx_d        = idx_q;
    res_id_d     = res_id_q;
    res_status_d = res_status_q;

    // default reads: scan read-ahead and free-stack top
    act_req_o       = '0;
    act_req_o.raddr = tia_pkg::act_addr(class_q, idx_q + 1'b1);
    frd_req_o       = '0;
    frd_req_o.raddr = tia_pkg::frd_addr(class_q, frd_pop_idx);

    unique case (state_q)
      tia_pkg::ST_IDLE: begin
        if (in_fire_i) begin
          state_d = tia_pkg::ST_DECODE;
        end
      end

      tia_pkg::ST_DECODE: begin
        res_id_d     = '0;
        res_status_d = tia_pkg::STAT_OK;
        state_d      = tia_pkg::ST_RESP;
        case (action_q)
          tia_pkg::ACT_ALLOC: begin
            if (!cls_ok || act_full) begin
              res_status_d = tia_pkg::STAT_FULL;
            end else begin
              cnt_d[class_q] = cnt_inc;
              if (cnt_inc == '1 && cur_frd_cnt != '0) begin
                // counter hit all ones: hand out a freed ID instead
                frd_cnt_d[class_q] = frd_cnt_m1;
                state_d            = tia_pkg::ST_POP;
              end else begin
                act_req_o.we       = 1'b1;
                act_req_o.waddr    = tia_pkg::act_addr(class_q, act_push_idx);
                act_req_o.wdata    = cnt_inc;
                act_cnt_d[class_q] = cur_act_cnt + 1'b1;
                res_id_d           = cnt_inc;
              end
            end
          end
          tia_pkg::ACT_RECLAIM: begin
            if (!cls_ok || cur_act_cnt == '0) begin
              res_status_d = tia_pkg::STAT_NOT_ACTIVE;
            end else begin
              act_req_o.raddr = tia_pkg::act_addr(class_q, '0);
              idx_d           = '0;
              state_d         = tia_pkg::ST_SCAN;
            end
          end
          tia_pkg::ACT_CLEAR: begin
            for (int i = 0; i < tia_pkg::NUM_CLASSES; i++) begin
              cnt_d[i]     = '0;
              act_cnt_d[i] = '0;
              frd_cnt_d[i] = '0;
            end
          end
          default: ;
        endcase
      end

      // freed ID arrives from the stack top
      tia_pkg::ST_POP: begin
        act_req_o.we       = 1'b1;
        act_req_o.waddr    = tia_pkg::act_addr(class_q, act_push_idx);
        act_req_o.wdata    = frd_rdata_i;
        act_cnt_d[class_q] = cur_act_cnt + 1'b1;
        res_id_d           = frd_rdata_i;
        state_d            = tia_pkg::ST_RESP;
      end

      // one entry compared per cycle, next one already being read
      tia_pkg::ST_SCAN: begin
        if (act_rdata_i == rel_q) begin
          if (frd_full) begin
            res_status_d = tia_pkg::STAT_FULL;
            state_d      = tia_pkg::ST_RESP;
          end else begin
            frd_req_o.we       = 1'b1;
            frd_req_o.waddr    = tia_pkg::frd_addr(class_q, frd_push_idx);
            frd_req_o.wdata    = rel_q;
            frd_cnt_d[class_q] = cur_frd_cnt + 1'b1;
            act_req_o.raddr    = tia_pkg::act_addr(class_q, last_idx);
            state_d            = tia_pkg::ST_SWAP;
          end
        end else if (idx_q == last_idx) begin
          res_status_d = tia_pkg::STAT_NOT_ACTIVE;
          state_d      = tia_pkg::ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // move last active entry into the freed slot
      tia_pkg::ST_SWAP: begin
        act_req_o.we       = 1'b1;
        act_req_o.waddr    = tia_pkg::act_addr(class_q, idx_q);
        act_req_o.wdata    = act_rdata_i;
        act_cnt_d[class_q] = act_cnt_m1;
        state_d            = tia_pkg::ST_RESP;
      end

      tia_pkg::ST_RESP: begin
        if (res_ready_i) begin
          state_d = tia_pkg::ST_IDLE;
        end
      end

      default: state_d = tia_pkg::ST_IDLE;
    endcase
  end

  assign busy_o        = state_q != tia_pkg::ST_IDLE;
  assign res_valid_o   = state_q == tia_pkg::ST_RESP;
  assign res_o.id      = res_id_q;
  assign res_o.status  = res_status_q;

  // Assertions
  for (genvar g = 0; g < tia_pkg::NUM_CLASSES; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      act_cnt_q[g] <= tia_pkg::ACT_CW'(tia_pkg::ACTIVE_DEPTH) &&
      frd_cnt_q[g] <= tia_pkg::FRD_CW'(tia_pkg::FREED_DEPTH))
      else $error("list count beyond depth");

    assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == tia_pkg::ST_DECODE && action_q == tia_pkg::ACT_CLEAR) |=>
      (cnt_q[g] == '0 && act_cnt_q[g] == '0 && frd_cnt_q[g] == '0))
      else $error("clear left class state behind");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tia_pkg::ST_SCAN |-> (cls_ok && cur_act_cnt != '0 && idx_q <= last_idx))
    else $error("scan index past end of active list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tia_pkg::ST_SWAP |-> $past(state_q) == tia_pkg::ST_SCAN && cur_act_cnt != '0)
    else $error("swap without a preceding match");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tia_pkg::ST_POP |-> (cnt_q[class_q] == '1 && !act_full))
    else $error("free stack popped off the wrap point");

endmodule

FILE: rtl/core/typed_id_allocator_with_free_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed ID allocator with free list
// Three ID classes, each with a wrapping counter, an active list and a stack
// of freed IDs, held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// One word is worked on at a time; the next word is taken once the result
// has moved to the output register. Allocate goes from decode to response,
// through a pop state when the counter reaches all ones and a freed ID is
// popped; clear and rejected words go from decode straight to response.
// Reclaim walks the active list of its class through the active-list RAM
// read port, one entry per cycle, and on a hit with room in the freed stack
// adds a swap write-back. RAM contents are not cleared
// on reset or clear; only the per-class counts are, so no clearing pass runs.
module typed_id_allocator_with_free_list (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   action_i,
  input  logic [tia_pkg::CLS_W-1:0]    id_class_i,
  input  logic [tia_pkg::ID_WIDTH-1:0] release_id_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tia_pkg::ID_WIDTH-1:0] issued_id_o,
  output logic [1:0]                   status_o
);

  logic                         busy;
  logic                         in_fire;
  tia_pkg::act_req_t            act_req;
  tia_pkg::frd_req_t            frd_req;
  logic [tia_pkg::ID_WIDTH-1:0] act_rdata, frd_rdata;
  logic                         res_valid, res_ready;
  tia_pkg::result_t             res;

  logic                         out_valid_q, out_valid_d;
  logic [tia_pkg::ID_WIDTH-1:0] out_id_q;
  logic [1:0]                   out_status_q;

  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;

  tia_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .action_i     (action_i),
    .id_class_i   (id_class_i),
    .release_id_i (release_id_i),
    .busy_o       (busy),
    .act_req_o    (act_req),
    .act_rdata_i  (act_rdata),
    .frd_req_o    (frd_req),
    .frd_rdata_i  (frd_rdata),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  // Active lists of all classes
  tia_ram #(
    .DEPTH (tia_pkg::ACT_WORDS),
    .WIDTH (tia_pkg::ID_WIDTH)
  ) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (act_req.we),
    .waddr_i (act_req.waddr),
    .wdata_i (act_req.wdata),
    .raddr_i (act_req.raddr),
    .rdata_o (act_rdata)
  );

  // Freed-ID stacks of all classes
  tia_ram #(
    .DEPTH (tia_pkg::FRD_WORDS),
    .WIDTH (tia_pkg::ID_WIDTH)
  ) u_frd_ram (
    .clk_i   (clk_i),
    .we_i    (frd_req.we),
    .waddr_i (frd_req.waddr),
    .wdata_i (frd_req.wdata),
    .raddr_i (frd_req.raddr),
    .rdata_o (frd_rdata)
  );

  // Output register: free when empty or being taken
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_id_q     <= res.id;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign issued_id_o = out_id_q;
  assign status_o    = out_status_q;

endmodule
